[hdl/fsmr_pkg.sv]
// fsmr_pkg: shared widths, constants and codes of the fault slip rotation block
// used by fsmr_sincos and fault_slip_to_mesh_rotation; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package fsmr_pkg;

   // input and result formats
   localparam int AngleFracBits = 8;
   localparam int AngleW        = 18;
   localparam int SlipW         = 32;

   // angle reduction
   localparam int FullTurn    = 360 << AngleFracBits;
   localparam int QuarterTurn = 90 << AngleFracBits;
   localparam int RedW        = $clog2(FullTurn);
   localparam int ArgW        = $clog2(QuarterTurn);

   // degrees to radians, pi/180 in Q40
   localparam logic [34:0] DegToRadQ40 = 35'd19190098069;
   localparam int RadShift = 10 + AngleFracBits;

   // trig datapath widths
   localparam int XW    = 31;
   localparam int X2W   = 32;
   localparam int TW    = 31;
   localparam int TrigW = 32;
   localparam logic [TW-1:0] Q30One = TW'(1) << 30;

   // series evaluation
   localparam int SeriesTerms  = 5;
   localparam int SeriesStages = 3 * SeriesTerms;
   localparam int ScStages     = 4 + SeriesStages + 2;

   localparam logic [63:0] Two32 = 64'd1 << 32;

   localparam logic [7:0] SinDiv [SeriesTerms] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [7:0] CosDiv [SeriesTerms] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12};

   // floor(2^32 / k) for the divide-by-constant steps
   localparam logic [31:0] SinRecip [SeriesTerms] = '{
      32'(Two32 / 64'd110), 32'(Two32 / 64'd72), 32'(Two32 / 64'd42),
      32'(Two32 / 64'd20), 32'(Two32 / 64'd6)};
   localparam logic [31:0] CosRecip [SeriesTerms] = '{
      32'(Two32 / 64'd132), 32'(Two32 / 64'd90), 32'(Two32 / 64'd56),
      32'(Two32 / 64'd30), 32'(Two32 / 64'd12)};

   // register map
   typedef enum logic [1:0] {
      CsrFirstAxis  = 2'd0,
      CsrSecondAxis = 2'd1,
      CsrThirdAxis  = 2'd2,
      CsrApplyMap   = 2'd3
   } csr_index_type;

   // axis source codes, the two remaining codes pass through
   typedef enum logic [2:0] {
      AxisEast  = 3'd0,
      AxisWest  = 3'd1,
      AxisNorth = 3'd2,
      AxisSouth = 3'd3,
      AxisDown  = 3'd4,
      AxisUp    = 3'd5
   } axis_code_type;

   localparam logic [2:0] FirstAxisReset  = AxisEast;
   localparam logic [2:0] SecondAxisReset = AxisNorth;
   localparam logic [2:0] ThirdAxisReset  = AxisUp;

endpackage

`default_nettype wire

[hdl/fsmr_sincos.sv]
// fsmr_sincos: pipelined fixed-point sine and cosine of one angle in degrees
// depends on fsmr_pkg; stage enables come from the top level valid chain
`timescale 1ns / 1ps
`default_nettype none

module fsmr_sincos (
   input  logic                               clock,
   input  logic [fsmr_pkg::ScStages-1:0]      en,
   input  logic signed [fsmr_pkg::AngleW-1:0] angle,
   output logic signed [fsmr_pkg::TrigW-1:0]  sin_val,
   output logic signed [fsmr_pkg::TrigW-1:0]  cos_val
);

   localparam int AW  = fsmr_pkg::AngleW;
   localparam int RW  = fsmr_pkg::RedW;
   localparam int GW  = fsmr_pkg::ArgW;
   localparam int XW  = fsmr_pkg::XW;
   localparam int X2W = fsmr_pkg::X2W;
   localparam int TW  = fsmr_pkg::TW;
   localparam int CW  = fsmr_pkg::TrigW;
   localparam int NT  = fsmr_pkg::SeriesTerms;
   localparam int NS  = fsmr_pkg::SeriesStages;
   localparam int QT  = fsmr_pkg::QuarterTurn;
   localparam int StF1 = 4 + NS;
   localparam int StF2 = 5 + NS;

   // stage 0: reduce into one full turn
   logic signed [AW+1:0] ang_wide;
   logic signed [AW+1:0] turn_wide;
   logic signed [AW+1:0] red_wide;
   logic [RW-1:0]        red_ff;

   always_comb begin
      ang_wide  = (AW+2)'(angle);
      turn_wide = (AW+2)'(fsmr_pkg::FullTurn);
      if (ang_wide < 0) begin
         if (ang_wide + turn_wide < 0) begin
            red_wide = ang_wide + turn_wide + turn_wide;
         end else begin
            red_wide = ang_wide + turn_wide;
         end
      end else if (ang_wide >= turn_wide) begin
         red_wide = ang_wide - turn_wide;
      end else begin
         red_wide = ang_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         red_ff <= RW'(red_wide);
      end
   end

   // stage 1: quadrant and remainder
   logic [1:0]    quad_in;
   logic [GW-1:0] rem_in;
   logic [1:0]    quad1_ff;
   logic [GW-1:0] rem1_ff;

   always_comb begin
      priority if (red_ff >= RW'(3 * QT)) begin
         quad_in = 2'd3;
         rem_in  = GW'(red_ff - RW'(3 * QT));
      end else if (red_ff >= RW'(2 * QT)) begin
         quad_in = 2'd2;
         rem_in  = GW'(red_ff - RW'(2 * QT));
      end else if (red_ff >= RW'(QT)) begin
         quad_in = 2'd1;
         rem_in  = GW'(red_ff - RW'(QT));
      end else begin
         quad_in = 2'd0;
         rem_in  = GW'(red_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         quad1_ff <= quad_in;
         rem1_ff  <= rem_in;
      end
   end

   // stage 2: radians in q30, rounded
   logic [GW+34:0] rad_prod;
   logic [XW-1:0]  x2st_ff;
   logic [1:0]     quad2_ff;

   assign rad_prod = (GW+35)'(rem1_ff) * (GW+35)'(fsmr_pkg::DegToRadQ40)
                   + ((GW+35)'(1) << (fsmr_pkg::RadShift - 1));

   always_ff @(posedge clock) begin
      if (en[2]) begin
         x2st_ff  <= XW'(rad_prod >> fsmr_pkg::RadShift);
         quad2_ff <= quad1_ff;
      end
   end

   // stage 3: square of the argument
   logic [2*XW-1:0] sq_prod;
   logic [XW-1:0]   x3_ff;
   logic [X2W-1:0]  xx3_ff;
   logic [1:0]      quad3_ff;

   assign sq_prod = (2*XW)'(x2st_ff) * (2*XW)'(x2st_ff) + ((2*XW)'(1) << 29);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         x3_ff    <= x2st_ff;
         xx3_ff   <= X2W'(sq_prod >> 30);
         quad3_ff <= quad2_ff;
      end
   end

   // argument, square and quadrant ride along the series stages
   logic [XW-1:0]  x_line_ff  [NS];
   logic [X2W-1:0] xx_line_ff [NS];
   logic [1:0]     q_line_ff  [NS];

   always_ff @(posedge clock) begin
      for (int n = 0; n < NS; n++) begin
         if (en[4+n]) begin
            if (n == 0) begin
               x_line_ff[n]  <= x3_ff;
               xx_line_ff[n] <= xx3_ff;
               q_line_ff[n]  <= quad3_ff;
            end else begin
               x_line_ff[n]  <= x_line_ff[n-1];
               xx_line_ff[n] <= xx_line_ff[n-1];
               q_line_ff[n]  <= q_line_ff[n-1];
            end
         end
      end
   end

   // series terms: multiply, reciprocal multiply, correct and subtract
   logic [31:0]   pa_s_ff [NT];
   logic [31:0]   pa_c_ff [NT];
   logic [63:0]   mb_s_ff [NT];
   logic [63:0]   mb_c_ff [NT];
   logic [31:0]   pb_s_ff [NT];
   logic [31:0]   pb_c_ff [NT];
   logic [TW-1:0] ts_ff   [NT];
   logic [TW-1:0] tc_ff   [NT];

   for (genvar j = 0; j < NT; j++) begin : g_term
      logic [TW-1:0]     ts_prev;
      logic [TW-1:0]     tc_prev;
      logic [X2W-1:0]    xx_src;
      logic [X2W+TW-1:0] prod_s;
      logic [X2W+TW-1:0] prod_c;
      logic [31:0]       q0_s;
      logic [31:0]       q0_c;
      logic [31:0]       rem_s;
      logic [31:0]       rem_c;
      logic [31:0]       quo_s;
      logic [31:0]       quo_c;

      if (j == 0) begin : g_first
         assign ts_prev = fsmr_pkg::Q30One;
         assign tc_prev = fsmr_pkg::Q30One;
         assign xx_src  = xx3_ff;
      end else begin : g_next
         assign ts_prev = ts_ff[j-1];
         assign tc_prev = tc_ff[j-1];
         assign xx_src  = xx_line_ff[3*j-1];
      end

      assign prod_s = (X2W+TW)'(xx_src) * (X2W+TW)'(ts_prev);
      assign prod_c = (X2W+TW)'(xx_src) * (X2W+TW)'(tc_prev);

      // quotient estimate is low by at most one
      assign q0_s  = mb_s_ff[j][63:32];
      assign q0_c  = mb_c_ff[j][63:32];
      assign rem_s = pb_s_ff[j] - q0_s * 32'(fsmr_pkg::SinDiv[j]);
      assign rem_c = pb_c_ff[j] - q0_c * 32'(fsmr_pkg::CosDiv[j]);
      assign quo_s = q0_s + 32'(rem_s >= 32'(fsmr_pkg::SinDiv[j]));
      assign quo_c = q0_c + 32'(rem_c >= 32'(fsmr_pkg::CosDiv[j]));

      always_ff @(posedge clock) begin
         if (en[4+3*j]) begin
            pa_s_ff[j] <= 32'(prod_s >> 30);
            pa_c_ff[j] <= 32'(prod_c >> 30);
         end
         if (en[5+3*j]) begin
            mb_s_ff[j] <= 64'(pa_s_ff[j]) * 64'(fsmr_pkg::SinRecip[j]);
            mb_c_ff[j] <= 64'(pa_c_ff[j]) * 64'(fsmr_pkg::CosRecip[j]);
            pb_s_ff[j] <= pa_s_ff[j];
            pb_c_ff[j] <= pa_c_ff[j];
         end
         if (en[6+3*j]) begin
            ts_ff[j] <= fsmr_pkg::Q30One - TW'(quo_s);
            tc_ff[j] <= fsmr_pkg::Q30One - TW'(quo_c);
         end
      end
   end

   // final products: sine in the first quadrant and the cosine half step
   logic [XW+TW-1:0]  fin_s_prod;
   logic [X2W+TW-1:0] fin_c_prod;
   logic [X2W-1:0]    half_d;
   logic [TW-1:0]     cv_in;
   logic [31:0]       sv_ff;
   logic [TW-1:0]     cv_ff;
   logic [1:0]        quadf_ff;

   assign fin_s_prod = (XW+TW)'(x_line_ff[NS-1]) * (XW+TW)'(ts_ff[NT-1]);
   assign fin_c_prod = (X2W+TW)'(xx_line_ff[NS-1]) * (X2W+TW)'(tc_ff[NT-1]);
   assign half_d     = X2W'(fin_c_prod >> 31);
   assign cv_in      = (half_d >= X2W'(fsmr_pkg::Q30One)) ? '0
                     : fsmr_pkg::Q30One - TW'(half_d);

   always_ff @(posedge clock) begin
      if (en[StF1]) begin
         sv_ff    <= 32'(fin_s_prod >> 30);
         cv_ff    <= cv_in;
         quadf_ff <= q_line_ff[NS-1];
      end
   end

   // quadrant fold
   logic signed [CW-1:0] sv_s;
   logic signed [CW-1:0] cv_s;
   logic signed [CW-1:0] sin_in;
   logic signed [CW-1:0] cos_in;
   logic signed [CW-1:0] sin_ff;
   logic signed [CW-1:0] cos_ff;

   always_comb begin
      sv_s = signed'(CW'(sv_ff));
      cv_s = signed'(CW'(cv_ff));
      unique case (quadf_ff)
         2'd0: begin
            sin_in = sv_s;
            cos_in = cv_s;
         end
         2'd1: begin
            sin_in = cv_s;
            cos_in = -sv_s;
         end
         2'd2: begin
            sin_in = -sv_s;
            cos_in = -cv_s;
         end
         default: begin
            sin_in = -cv_s;
            cos_in = sv_s;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[StF2]) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

`default_nettype wire

[hdl/fault_slip_to_mesh_rotation.sv]
// fault_slip_to_mesh_rotation: top level, rotation matrix, slip products, axis map
// depends on fsmr_pkg and fsmr_sincos
`timescale 1ns / 1ps
`default_nettype none

// Usage
// req_*: one transfer carries strike, dip and rake (signed degrees, 8 fraction
//   bits) and three slip components in Q16.16. A transfer happens at a rising
//   edge with req_valid high and req_stall low.
// rsp_*: one result per request, in order: out_x, out_y, out_z and a flag that
//   says some component was clipped to 32-bit signed range.
// csr_*: csr_write with csr_index selects first, second, third axis code or
//   the mapping enable; write only while no request is in flight.
// Stages: 26 register stages, the first loaded at the accepting edge and the
//   last driving rsp_valid and the result. One stage each for angle
//   reduction, split, radian scale, square, fifteen series stages, two trig
//   finish stages, two matrix stages, slip products, sum and axis map, clip.
// Throughput: one transfer per cycle while req_stall is low; every stage holds
//   a valid bit.
// Stall: rsp_stall freezes only the stages that are full; empty stages further
//   up keep filling, so req_stall rises only when the whole pipe is full.
// Reset: synchronous, clears all valid bits and loads the default axis codes.
module fault_slip_to_mesh_rotation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [fsmr_pkg::AngleW-1:0] req_strike_angle,
   input  logic signed [fsmr_pkg::AngleW-1:0] req_dip_angle,
   input  logic signed [fsmr_pkg::AngleW-1:0] req_rake_angle,
   input  logic signed [fsmr_pkg::SlipW-1:0]  req_slip_along_strike,
   input  logic signed [fsmr_pkg::SlipW-1:0]  req_slip_along_dip,
   input  logic signed [fsmr_pkg::SlipW-1:0]  req_slip_normal,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [fsmr_pkg::SlipW-1:0]  rsp_out_x,
   output logic signed [fsmr_pkg::SlipW-1:0]  rsp_out_y,
   output logic signed [fsmr_pkg::SlipW-1:0]  rsp_out_z,
   output logic                               rsp_saturated,
   input  logic                               csr_write,
   input  logic [1:0]                         csr_index,
   input  logic [2:0]                         csr_data
);

   localparam int Sc      = fsmr_pkg::ScStages;
   localparam int StL1    = Sc;
   localparam int StL2    = Sc + 1;
   localparam int StPrd   = Sc + 2;
   localparam int StSum   = Sc + 3;
   localparam int StOut   = Sc + 4;
   localparam int NStages = Sc + 5;
   localparam int SlipLen = Sc + 2;
   localparam int CW      = fsmr_pkg::TrigW;
   localparam int SW      = fsmr_pkg::SlipW;
   localparam int EW      = CW + 1;
   localparam int PW      = SW + 2;
   localparam int NedW    = PW + 2;
   localparam int ResW    = NedW + 1;

   localparam logic signed [ResW-1:0] SatMax = ResW'(2147483647);
   localparam logic signed [ResW-1:0] SatMin = -SatMax - 1;
   localparam logic signed [SW-1:0]   OutMax = 32'sh7fffffff;
   localparam logic signed [SW-1:0]   OutMin = 32'sh80000000;

   // rounded q30 product of two trig values
   function automatic logic signed [CW-1:0] qmul_trig(input logic signed [CW-1:0] a,
                                                       input logic signed [CW-1:0] b);
      logic [CW-1:0]   ma;
      logic [CW-1:0]   mb;
      logic [2*CW-1:0] prod;
      logic [CW-1:0]   mq;
      ma   = a[CW-1] ? CW'(-a) : CW'(a);
      mb   = b[CW-1] ? CW'(-b) : CW'(b);
      prod = (2*CW)'(ma) * (2*CW)'(mb) + ((2*CW)'(1) << 29);
      mq   = CW'(prod >> 30);
      return (a[CW-1] ^ b[CW-1]) ? -signed'(mq) : signed'(mq);
   endfunction

   // rounded product of a slip component and a q30 matrix entry
   function automatic logic signed [PW-1:0] qmul_slip(input logic signed [SW-1:0] u,
                                                       input logic signed [EW-1:0] m);
      logic [SW-1:0]    mu;
      logic [EW-1:0]    mm;
      logic [SW+EW-1:0] prod;
      logic [PW-1:0]    mq;
      mu   = u[SW-1] ? SW'(-u) : SW'(u);
      mm   = m[EW-1] ? EW'(-m) : EW'(m);
      prod = (SW+EW)'(mu) * (SW+EW)'(mm) + ((SW+EW)'(1) << 29);
      mq   = PW'(prod >> 30);
      return (u[SW-1] ^ m[EW-1]) ? -signed'(mq) : signed'(mq);
   endfunction

   // axis selection with negation; unknown codes keep their own position
   function automatic logic signed [ResW-1:0] pick_axis(input logic [2:0] code,
                                                         input logic signed [ResW-1:0] same,
                                                         input logic signed [ResW-1:0] n,
                                                         input logic signed [ResW-1:0] e,
                                                         input logic signed [ResW-1:0] d);
      logic signed [ResW-1:0] v;
      unique case (code)
         fsmr_pkg::AxisEast:  v = e;
         fsmr_pkg::AxisWest:  v = -e;
         fsmr_pkg::AxisNorth: v = n;
         fsmr_pkg::AxisSouth: v = -n;
         fsmr_pkg::AxisDown:  v = d;
         fsmr_pkg::AxisUp:    v = -d;
         default:             v = same;
      endcase
      return v;
   endfunction

   // configuration registers
   logic [2:0] first_code_ff;
   logic [2:0] second_code_ff;
   logic [2:0] third_code_ff;
   logic       apply_map_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_code_ff  <= fsmr_pkg::FirstAxisReset;
         second_code_ff <= fsmr_pkg::SecondAxisReset;
         third_code_ff  <= fsmr_pkg::ThirdAxisReset;
         apply_map_ff   <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            fsmr_pkg::CsrFirstAxis:  first_code_ff  <= csr_data;
            fsmr_pkg::CsrSecondAxis: second_code_ff <= csr_data;
            fsmr_pkg::CsrThirdAxis:  third_code_ff  <= csr_data;
            fsmr_pkg::CsrApplyMap:   apply_map_ff   <= csr_data[0];
         endcase
      end
   end

   // valid chain, a stage advances when empty or when the next one advances
   logic [NStages-1:0] valid_ff;
   logic [NStages-1:0] valid_in;
   logic [NStages-1:0] en;

   always_comb begin
      en[NStages-1] = !valid_ff[NStages-1] || !rsp_stall;
      for (int i = NStages - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      for (int i = 0; i < NStages; i++) begin
         if (!en[i]) begin
            valid_in[i] = valid_ff[i];
         end else if (i == 0) begin
            valid_in[i] = req_valid;
         end else begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[StOut];

   // sine and cosine of the three angles
   logic signed [CW-1:0] ss, cs, sd, cd, sr, cr;

   fsmr_sincos u_strike (
      .clock   (clock),
      .en      (en[Sc-1:0]),
      .angle   (req_strike_angle),
      .sin_val (ss),
      .cos_val (cs)
   );

   fsmr_sincos u_dip (
      .clock   (clock),
      .en      (en[Sc-1:0]),
      .angle   (req_dip_angle),
      .sin_val (sd),
      .cos_val (cd)
   );

   fsmr_sincos u_rake (
      .clock   (clock),
      .en      (en[Sc-1:0]),
      .angle   (req_rake_angle),
      .sin_val (sr),
      .cos_val (cr)
   );

   // slip components follow the trig pipeline
   logic signed [SW-1:0] slip_ff [SlipLen][3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < SlipLen; i++) begin
         if (en[i]) begin
            if (i == 0) begin
               slip_ff[i][0] <= req_slip_along_strike;
               slip_ff[i][1] <= req_slip_along_dip;
               slip_ff[i][2] <= req_slip_normal;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  slip_ff[i][k] <= slip_ff[i-1][k];
               end
            end
         end
      end
   end

   // first level of trig products
   logic signed [CW-1:0] rs_ss_ff, cr_cs_ff, sr_cs_ff, ss_cd_ff, sd_ss_ff, sr_cd_ff;
   logic signed [CW-1:0] ss_cr_ff, cd_cr_ff, sd_cs_ff, sd_sr_ff, sd_cr_ff;
   logic signed [CW-1:0] cs1_ff, cd1_ff, cr1_ff;

   always_ff @(posedge clock) begin
      if (en[StL1]) begin
         rs_ss_ff <= qmul_trig(sr, ss);
         cr_cs_ff <= qmul_trig(cr, cs);
         sr_cs_ff <= qmul_trig(sr, cs);
         ss_cd_ff <= qmul_trig(ss, cd);
         sd_ss_ff <= qmul_trig(sd, ss);
         sr_cd_ff <= qmul_trig(sr, cd);
         ss_cr_ff <= qmul_trig(ss, cr);
         cd_cr_ff <= qmul_trig(cd, cr);
         sd_cs_ff <= qmul_trig(sd, cs);
         sd_sr_ff <= qmul_trig(sd, sr);
         sd_cr_ff <= qmul_trig(sd, cr);
         cs1_ff   <= cs;
         cd1_ff   <= cd;
         cr1_ff   <= cr;
      end
   end

   // rotation matrix entries in q30
   logic signed [EW-1:0] mat_ff [3][3];

   always_ff @(posedge clock) begin
      if (en[StL2]) begin
         mat_ff[0][0] <= EW'(qmul_trig(rs_ss_ff, cd1_ff)) + EW'(cr_cs_ff);
         mat_ff[0][1] <= -EW'(sr_cs_ff) + EW'(qmul_trig(ss_cd_ff, cr1_ff));
         mat_ff[0][2] <= -EW'(sd_ss_ff);
         mat_ff[1][0] <= -EW'(qmul_trig(sr_cd_ff, cs1_ff)) + EW'(ss_cr_ff);
         mat_ff[1][1] <= -EW'(rs_ss_ff) - EW'(qmul_trig(cd_cr_ff, cs1_ff));
         mat_ff[1][2] <= EW'(sd_cs_ff);
         mat_ff[2][0] <= -EW'(sd_sr_ff);
         mat_ff[2][1] <= -EW'(sd_cr_ff);
         mat_ff[2][2] <= -EW'(cd1_ff);
      end
   end

   // slip times matrix entries
   logic signed [PW-1:0] prod_ff [3][3];

   always_ff @(posedge clock) begin
      if (en[StPrd]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= qmul_slip(slip_ff[SlipLen-1][c], mat_ff[r][c]);
            end
         end
      end
   end

   // north, east, down sums and axis mapping
   logic signed [ResW-1:0] ned [3];
   logic signed [ResW-1:0] res_in [3];
   logic signed [ResW-1:0] res_ff [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         ned[r] = ResW'(prod_ff[r][0]) + ResW'(prod_ff[r][1]) + ResW'(prod_ff[r][2]);
      end
      if (apply_map_ff) begin
         res_in[0] = pick_axis(first_code_ff, ned[0], ned[0], ned[1], ned[2]);
         res_in[1] = pick_axis(second_code_ff, ned[1], ned[0], ned[1], ned[2]);
         res_in[2] = pick_axis(third_code_ff, ned[2], ned[0], ned[1], ned[2]);
      end else begin
         res_in[0] = ned[0];
         res_in[1] = ned[1];
         res_in[2] = ned[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[StSum]) begin
         res_ff <= res_in;
      end
   end

   // clip to 32-bit signed, output register
   logic signed [SW-1:0] clip_in [3];
   logic [2:0]           clip_hit;
   logic signed [SW-1:0] out_ff [3];
   logic                 sat_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (res_ff[k] > SatMax) begin
            clip_in[k]  = OutMax;
            clip_hit[k] = 1'b1;
         end else if (res_ff[k] < SatMin) begin
            clip_in[k]  = OutMin;
            clip_hit[k] = 1'b1;
         end else begin
            clip_in[k]  = SW'(res_ff[k]);
            clip_hit[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[StOut]) begin
         out_ff <= clip_in;
         sat_ff <= |clip_hit;
      end
   end

   assign rsp_out_x     = out_ff[0];
   assign rsp_out_y     = out_ff[1];
   assign rsp_out_z     = out_ff[2];
   assign rsp_saturated = sat_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff[0])
      else $error("input stalled while first stage is empty");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted transfer missing from first stage");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_out_x == OutMax || rsp_out_x == OutMin ||
          rsp_out_y == OutMax || rsp_out_y == OutMin ||
          rsp_out_z == OutMax || rsp_out_z == OutMin))
      else $error("saturation flag without a clipped component");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !valid_ff[StSum] |=> !rsp_valid)
      else $error("result repeated after transfer");

endmodule

`default_nettype wire

[bench/testbench.sv]
// testbench: fault slip rotation block against a bit-exact predictor of the
// trig series, rotation matrix, axis map and clipping; depends on fsmr_pkg
`timescale 1ns / 1ps
`default_nettype none

// queue of predicted mesh components, checked in order
class slip_rotation_board;
   logic [31:0] exp_x[$];
   logic [31:0] exp_y[$];
   logic [31:0] exp_z[$];
   logic        exp_sat[$];
   int          errors;

   function new();
      errors = 0;
   endfunction

   function void note_request(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic s);
      exp_x.push_back(x);
      exp_y.push_back(y);
      exp_z.push_back(z);
      exp_sat.push_back(s);
   endfunction

   function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic s);
      logic [31:0] ex;
      logic [31:0] ey;
      logic [31:0] ez;
      logic        es;
      if (exp_x.size() == 0) begin
         $display("%0t unexpected result x=%h y=%h z=%h", $realtime, x, y, z);
         errors++;
         return;
      end
      ex = exp_x.pop_front();
      ey = exp_y.pop_front();
      ez = exp_z.pop_front();
      es = exp_sat.pop_front();
      if (x !== ex) begin
         $display("%0t out_x expected %h actual %h", $realtime, ex, x);
         errors++;
      end
      if (y !== ey) begin
         $display("%0t out_y expected %h actual %h", $realtime, ey, y);
         errors++;
      end
      if (z !== ez) begin
         $display("%0t out_z expected %h actual %h", $realtime, ez, z);
         errors++;
      end
      if (s !== es) begin
         $display("%0t saturated expected %b actual %b", $realtime, es, s);
         errors++;
      end
   endfunction

   function int pending();
      return exp_x.size();
   endfunction
endclass

module testbench;

   localparam int Latency = 26;
   localparam int WatchdogLimit = 2000;
   localparam int RandomItems = 1400;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [17:0] req_strike_angle;
   logic signed [17:0] req_dip_angle;
   logic signed [17:0] req_rake_angle;
   logic signed [31:0] req_slip_along_strike;
   logic signed [31:0] req_slip_along_dip;
   logic signed [31:0] req_slip_normal;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic               rsp_saturated;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [2:0]         csr_data;

   slip_rotation_board board;
   logic [2:0] map_code[3];
   logic       map_enable;
   bit         sending_done;
   int         idle_cycles;

   fault_slip_to_mesh_rotation dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // product of two Q30-scaled values, rounded half away from zero
   function automatic longint q30_product(longint a, longint b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] p;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = (ma * mb + 64'd536870912) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   // fixed-point sine and cosine of an angle in degrees with 8 fraction bits
   task automatic angle_trig(input logic signed [17:0] ang, output longint s, output longint c);
      longint      r;
      longint      quad;
      longint      a;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] d;
      longint      sv;
      longint      cv;
      longint      sin_div[5];
      longint      cos_div[5];
      sin_div = '{110, 72, 42, 20, 6};
      cos_div = '{132, 90, 56, 30, 12};
      r = longint'(ang) % 92160;
      if (r < 0) r += 92160;
      quad = r / 23040;
      a = r - quad * 23040;
      x = (64'(a) * 64'd19190098069 + (64'd1 << 17)) >> 18;
      x2 = (x * x + 64'd536870912) >> 30;
      t = 64'd1 << 30;
      for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(sin_div[i]);
      sv = longint'((x * t) >> 30);
      t = 64'd1 << 30;
      for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(cos_div[i]);
      d = ((x2 * t) >> 30) / 2;
      cv = d >= (64'd1 << 30) ? 0 : (longint'(1) << 30) - longint'(d);
      case (quad)
         0: begin s = sv; c = cv; end
         1: begin s = cv; c = -sv; end
         2: begin s = -sv; c = -cv; end
         default: begin s = -cv; c = sv; end
      endcase
   endtask

   function automatic longint axis_source(logic [2:0] code, int pos, longint ned[3]);
      case (code)
         fsmr_pkg::AxisEast:  return ned[1];
         fsmr_pkg::AxisWest:  return -ned[1];
         fsmr_pkg::AxisNorth: return ned[0];
         fsmr_pkg::AxisSouth: return -ned[0];
         fsmr_pkg::AxisDown:  return ned[2];
         fsmr_pkg::AxisUp:    return -ned[2];
         default:             return ned[pos];
      endcase
   endfunction

   function automatic logic [31:0] clip_word(longint v, ref logic sat);
      if (v > 64'sd2147483647) begin sat = 1'b1; return 32'h7fffffff; end
      if (v < -64'sd2147483648) begin sat = 1'b1; return 32'h80000000; end
      return v[31:0];
   endfunction

   // predicted mesh components for one accepted transfer
   task automatic predict_mesh_slip(input logic signed [17:0] st, dp, rk,
                                    input logic signed [31:0] u1, u2, u3);
      longint ss, cs, sd, cd, sr, cr;
      longint m[3][3];
      longint ned[3];
      longint res[3];
      logic   sat;
      logic [31:0] o[3];
      angle_trig(st, ss, cs);
      angle_trig(dp, sd, cd);
      angle_trig(rk, sr, cr);
      m[0][0] = q30_product(q30_product(sr, ss), cd) + q30_product(cr, cs);
      m[0][1] = -q30_product(sr, cs) + q30_product(q30_product(ss, cd), cr);
      m[0][2] = -q30_product(sd, ss);
      m[1][0] = -q30_product(q30_product(sr, cd), cs) + q30_product(ss, cr);
      m[1][1] = -q30_product(sr, ss) - q30_product(q30_product(cd, cr), cs);
      m[1][2] = q30_product(sd, cs);
      m[2][0] = -q30_product(sd, sr);
      m[2][1] = -q30_product(sd, cr);
      m[2][2] = -cd;
      for (int i = 0; i < 3; i++)
         ned[i] = q30_product(longint'(u1), m[i][0]) + q30_product(longint'(u2), m[i][1])
                + q30_product(longint'(u3), m[i][2]);
      for (int i = 0; i < 3; i++)
         res[i] = map_enable ? axis_source(map_code[i], i, ned) : ned[i];
      sat = 1'b0;
      for (int i = 0; i < 3; i++) o[i] = clip_word(res[i], sat);
      board.note_request(o[0], o[1], o[2], sat);
   endtask

   // one register write, then csr_write is dropped again before the task returns
   task automatic write_csr(fsmr_pkg::csr_index_type idx, logic [2:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         fsmr_pkg::CsrFirstAxis:  map_code[0] = value;
         fsmr_pkg::CsrSecondAxis: map_code[1] = value;
         fsmr_pkg::CsrThirdAxis:  map_code[2] = value;
         fsmr_pkg::CsrApplyMap:   map_enable = value[0];
      endcase
      @(posedge clock);
   endtask

   // wait for every predicted result to come back, then let the pipe run empty before touching registers
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   // one request transfer, with an optional random gap before it
   task automatic send_request(logic signed [17:0] st, dp, rk,
                               logic signed [31:0] u1, u2, u3, bit allow_gap);
      int gap;
      gap = allow_gap ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_strike_angle      <= st;
      req_dip_angle         <= dp;
      req_rake_angle        <= rk;
      req_slip_along_strike <= u1;
      req_slip_along_dip    <= u2;
      req_slip_normal       <= u3;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_mesh_slip(st, dp, rk, u1, u2, u3);
   endtask

   function automatic logic signed [17:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 18'($urandom);
         1: return 18'(23040 * $urandom_range(0, 8) - 92160);
         default: return 18'($signed($urandom_range(0, 184320)) - 92160);
      endcase
   endfunction

   function automatic logic signed [31:0] pick_slip();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      endcase
   endfunction

   // run a block of random transfers; no gaps in some stretches
   task automatic random_burst(int count);
      bit gaps;
      gaps = $urandom_range(0, 1);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) gaps = $urandom_range(0, 2) != 0;
         send_request(pick_angle(), pick_angle(), pick_angle(),
                      pick_slip(), pick_slip(), pick_slip(), gaps);
      end
   endtask

   // result side: random stall before each result, checking at each transfer
   initial begin
      bit calm;
      int stall_cycles;
      rsp_stall = 1'b1;
      calm = 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 60) == 0) calm = ~calm;
         stall_cycles = calm ? 0 : $urandom_range(0, 7);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (reset || !rsp_valid) @(posedge clock);
         board.check_result(rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated);
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || sending_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic signed [17:0] edge_ang[6];
      logic signed [31:0] edge_slip[4];
      int tail;
      board = new();
      sending_done = 1'b0;
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_strike_angle = '0;
      req_dip_angle = '0;
      req_rake_angle = '0;
      req_slip_along_strike = '0;
      req_slip_along_dip = '0;
      req_slip_normal = '0;
      csr_write = 1'b0;
      csr_index = fsmr_pkg::CsrFirstAxis;
      csr_data = '0;
      map_code[0] = fsmr_pkg::FirstAxisReset;
      map_code[1] = fsmr_pkg::SecondAxisReset;
      map_code[2] = fsmr_pkg::ThirdAxisReset;
      map_enable = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: range ends, quadrant edges, out-of-range angles, clipping
      edge_ang = '{-18'sd92160, 18'sd92160, 18'sd0, 18'sd23040, 18'sh20000, 18'sd131071};
      edge_slip = '{32'h7fffffff, 32'h80000000, 32'h00010000, 32'h0};
      for (int i = 0; i < 6; i++)
         send_request(edge_ang[i], edge_ang[(i + 1) % 6], edge_ang[(i + 3) % 6],
                      edge_slip[i % 4], edge_slip[(i + 1) % 4], edge_slip[(i + 2) % 4], 1'b0);
      for (int i = 0; i < 4; i++)
         send_request(18'sd11520, 18'(23040 * i), 18'sd46080, edge_slip[i],
                      edge_slip[i], edge_slip[i], 1'b1);

      // pause until everything has come back, then walk every axis code
      drain_pipe();
      for (int code = 0; code < 8; code++) begin
         write_csr(fsmr_pkg::CsrFirstAxis, 3'(code));
         write_csr(fsmr_pkg::CsrSecondAxis, 3'(7 - code));
         write_csr(fsmr_pkg::CsrThirdAxis, 3'(code + 3));
         write_csr(fsmr_pkg::CsrApplyMap, 3'(code % 2 == 0 ? 1 : 0));
         send_request(18'sd7680, 18'sd15360, -18'sd5000, 32'h7fffffff,
                      32'h80000000, 32'h12345678, 1'b0);
         drain_pipe();
      end

      // random phases with random settings, extremes among them
      for (int phase = 0; phase < 7; phase++) begin
         write_csr(fsmr_pkg::CsrFirstAxis, phase == 0 ? 3'd0 : 3'($urandom));
         write_csr(fsmr_pkg::CsrSecondAxis, phase == 0 ? 3'd7 : 3'($urandom));
         write_csr(fsmr_pkg::CsrThirdAxis, phase == 1 ? 3'd7 : 3'($urandom));
         write_csr(fsmr_pkg::CsrApplyMap, phase == 2 ? 3'd0 : 3'($urandom_range(0, 1)));
         random_burst(RandomItems / 7);
         drain_pipe();
      end

      sending_done = 1'b1;
      tail = 0;
      while (board.pending() != 0 && tail < 10000) begin
         @(posedge clock);
         tail++;
      end
      repeat (Latency + 4) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

`default_nettype wire
